@@ rtl/core/ucw_pkg.sv @@
// ----------------------------------------------------------------------------
// ucw_pkg
// shared types, constants and classification functions of the utf-8 decoder
// ----------------------------------------------------------------------------
package ucw_pkg;

	localparam int PIXEL_SUM_BITS = 16;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int CNT_W   = 3;
	localparam int COL_W   = 2;
	localparam int PIX_W   = 16;
	localparam int CELL_W  = 7;
	localparam int INC_W   = CELL_W + 1;
	localparam int LEN_W   = 3;

	localparam logic [CELL_W-1:0] CELL_RESET = 7'd8;

	// column classes
	localparam logic [COL_W-1:0] COL_ZERO = 2'd0;
	localparam logic [COL_W-1:0] COL_ONE  = 2'd1;
	localparam logic [COL_W-1:0] COL_TWO  = 2'd2;

	// sequence lengths
	localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

	// classified byte as it travels through the front queue
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eos;
		logic              cont;
		logic [LEN_W-1:0]  len;
	} byte_ent_t;

	// one decoded character on its way to the width stage
	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [CNT_W-1:0] nbytes;
		logic             last;
	} char_t;

	function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] l;
		if (b >= 8'hF0)      l = LEN_4;
		else if (b >= 8'hE0) l = LEN_3;
		else if (b >= 8'hC0) l = LEN_2;
		else                 l = LEN_1;
		return l;
	endfunction

	function automatic logic [COL_W-1:0] columns_of(input logic [CP_W-1:0] c);
		logic [COL_W-1:0] w;
		if (c < 21'h20 || (c >= 21'h7F && c < 21'hA0))          w = COL_ZERO;
		else if (c >= 21'h0300 && c <= 21'h036F)                w = COL_ZERO;
		else if (c < 21'h1100)                                  w = COL_ONE;
		else if (c == 21'h200B || c == 21'h200C || c == 21'h200D
			|| c == 21'hFEFF)                                   w = COL_ZERO;
		else if (c <= 21'h115F)                                 w = COL_TWO;
		else if (c >= 21'h2E80 && c <= 21'h303E)                w = COL_TWO;
		else if (c >= 21'h3041 && c <= 21'h33FF)                w = COL_TWO;
		else if (c >= 21'h3400 && c <= 21'h4DBF)                w = COL_TWO;
		else if (c >= 21'h4E00 && c <= 21'h9FFF)                w = COL_TWO;
		else if (c >= 21'hA000 && c <= 21'hA4CF)                w = COL_TWO;
		else if (c >= 21'hAC00 && c <= 21'hD7A3)                w = COL_TWO;
		else if (c >= 21'hF900 && c <= 21'hFAFF)                w = COL_TWO;
		else if (c >= 21'hFE30 && c <= 21'hFE6F)                w = COL_TWO;
		else if (c >= 21'hFF00 && c <= 21'hFF60)                w = COL_TWO;
		else if (c >= 21'hFFE0 && c <= 21'hFFE6)                w = COL_TWO;
		else if (c >= 21'h1F300 && c <= 21'h1FAFF)              w = COL_TWO;
		else if (c >= 21'h20000 && c <= 21'h3FFFD)              w = COL_TWO;
		else                                                    w = COL_ONE;
		return w;
	endfunction

endpackage

@@ rtl/core/ucw_stream_if.sv @@
// ----------------------------------------------------------------------------
// ucw stream interfaces
// valid/ready channels for raw text bytes and decoded characters
// ----------------------------------------------------------------------------
interface ucw_byte_if;
	import ucw_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              end_of_string;

	modport source(output valid, output text_byte, output end_of_string, input ready);
	modport sink(input valid, input text_byte, input end_of_string, output ready);
endinterface

interface ucw_char_if;
	import ucw_pkg::*;

	logic             valid;
	logic             ready;
	logic [CP_W-1:0]  code_point;
	logic [CNT_W-1:0] byte_count;
	logic [COL_W-1:0] columns;
	logic [PIX_W-1:0] width_pixels;
	logic             run_last;

	modport source(output valid, output code_point, output byte_count, output columns,
		output width_pixels, output run_last, input ready);
	modport sink(input valid, input code_point, input byte_count, input columns,
		input width_pixels, input run_last, output ready);
endinterface

@@ rtl/core/ucw_front.sv @@
// ----------------------------------------------------------------------------
// ucw_front
// accepts text bytes, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module ucw_front (
	input  logic              clk,
	input  logic              arst_n,
	ucw_byte_if.sink          bytes,
	output ucw_pkg::byte_ent_t head,
	output logic              head_valid,
	input  logic              head_pop
);
	import ucw_pkg::*;

	localparam int QUEUE_DEPTH = 2;

	byte_ent_t  mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	byte_ent_t  ent;

	always_comb begin
		ent.data = bytes.text_byte;
		ent.eos  = bytes.end_of_string;
		ent.cont = (bytes.text_byte[7:6] == 2'b10);
		ent.len  = seq_len(bytes.text_byte);
	end

	assign bytes.ready = (fill_q != 2'(QUEUE_DEPTH));
	assign push        = bytes.valid && bytes.ready;
	assign head_valid  = (fill_q != 2'd0);
	assign pop         = head_pop && head_valid;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= ent;
	end

endmodule

@@ rtl/core/ucw_decode.sv @@
// ----------------------------------------------------------------------------
// ucw_decode
// holds the open sequence, emits one character per cycle into a stage register while it is free
// ----------------------------------------------------------------------------
module ucw_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  ucw_pkg::byte_ent_t head,
	input  logic               head_valid,
	output logic               head_pop,
	output ucw_pkg::char_t     chr,
	output logic               chr_valid,
	input  logic               chr_ready
);
	import ucw_pkg::*;

	byte_ent_t        win_q [3];
	logic [1:0]       cnt_q;
	logic             last_q;
	logic             valid_s1;
	char_t            chr_s1;

	byte_ent_t        w [4];
	byte_ent_t        nwin [3];
	logic             st_bad;
	logic             busy;
	logic             take;
	logic [2:0]       cnt_w;
	logic             last_w;
	logic [LEN_W-1:0] l;
	logic             bad;
	logic             full;
	logic             emit;
	logic [2:0]       shift;
	logic [2:0]       rest;
	logic             s1_free;
	logic             advance;
	logic [CP_W-1:0]  cp;

	always_comb begin
		// stored window still has something to emit
		st_bad = (win_q[0].len > LEN_1 && cnt_q > 2'd1 && !win_q[1].cont)
			|| (win_q[0].len > LEN_2 && cnt_q > 2'd2 && !win_q[2].cont);
		busy = (cnt_q != 2'd0) && (last_q || st_bad || {1'b0, cnt_q} >= win_q[0].len);
		take = !busy && head_valid;

		w[0] = (cnt_q > 2'd0) ? win_q[0] : head;
		w[1] = (cnt_q > 2'd1) ? win_q[1] : head;
		w[2] = (cnt_q > 2'd2) ? win_q[2] : head;
		w[3] = head;
		cnt_w  = {1'b0, cnt_q} + 3'(take);
		last_w = take ? head.eos : last_q;

		l    = w[0].len;
		bad  = (l > LEN_1 && cnt_w > 3'd1 && !w[1].cont)
			|| (l > LEN_2 && cnt_w > 3'd2 && !w[2].cont)
			|| (l > LEN_3 && cnt_w > 3'd3 && !w[3].cont);
		full = (cnt_w >= l) && !bad;
		emit = (cnt_w != 3'd0) && (full || bad || last_w);
		shift = full ? l : LEN_1;
		rest  = cnt_w - shift;

		s1_free  = !valid_s1 || chr_ready;
		advance  = (cnt_w != 3'd0) && (!emit || s1_free);
		head_pop = take && advance;

		// plain bit assembly, broken sequences give the raw lead
		case (full ? l : LEN_1)
			LEN_2:   cp = CP_W'({w[0].data[4:0], w[1].data[5:0]});
			LEN_3:   cp = CP_W'({w[0].data[3:0], w[1].data[5:0], w[2].data[5:0]});
			LEN_4:   cp = {w[0].data[2:0], w[1].data[5:0], w[2].data[5:0], w[3].data[5:0]};
			default: cp = CP_W'(w[0].data);
		endcase

		nwin[0] = w[0];
		nwin[1] = w[1];
		nwin[2] = w[2];
		if (emit) begin
			case (shift)
				LEN_1: begin
					nwin[0] = w[1];
					nwin[1] = w[2];
					nwin[2] = w[3];
				end
				LEN_2: begin
					nwin[0] = w[2];
					nwin[1] = w[3];
				end
				LEN_3: begin
					nwin[0] = w[3];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			last_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				cnt_q  <= emit ? rest[1:0] : cnt_w[1:0];
				last_q <= last_w;
			end
			if (advance && emit) valid_s1 <= 1'b1;
			else if (chr_ready)  valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q[0] <= nwin[0];
			win_q[1] <= nwin[1];
			win_q[2] <= nwin[2];
		end
		if (advance && emit) begin
			chr_s1.cp     <= cp;
			chr_s1.nbytes <= shift;
			chr_s1.last   <= last_w && (rest == 3'd0);
		end
	end

	assign chr       = chr_s1;
	assign chr_valid = valid_s1;

endmodule

@@ rtl/core/ucw_width.sv @@
// ----------------------------------------------------------------------------
// ucw_width
// column lookup, saturating pixel accumulation and the output register
// ----------------------------------------------------------------------------
module ucw_width (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ucw_pkg::CELL_W-1:0]  cell_width,
	input  ucw_pkg::char_t              chr,
	input  logic                        chr_valid,
	output logic                        chr_ready,
	ucw_char_if.source                  chars
);
	import ucw_pkg::*;

	logic                      out_valid_q;
	logic [CP_W-1:0]           cp_q;
	logic [CNT_W-1:0]          nbytes_q;
	logic [COL_W-1:0]          cols_q;
	logic [PIX_W-1:0]          pix_q;
	logic                      last_q;
	logic [PIXEL_SUM_BITS-1:0] total_q;

	logic                      load;
	logic [COL_W-1:0]          cols;
	logic [INC_W-1:0]          inc;
	logic [PIXEL_SUM_BITS:0]   sum;
	logic [PIXEL_SUM_BITS-1:0] sat;

	assign chr_ready = !out_valid_q || chars.ready;
	assign load      = chr_valid && chr_ready;

	always_comb begin
		cols = columns_of(chr.cp);
		case (cols)
			COL_TWO: inc = {cell_width, 1'b0};
			COL_ONE: inc = {1'b0, cell_width};
			default: inc = '0;
		endcase
		sum = {1'b0, total_q} + (PIXEL_SUM_BITS+1)'(inc);
		// clamp at all ones
		sat = sum[PIXEL_SUM_BITS] ? {PIXEL_SUM_BITS{1'b1}} : sum[PIXEL_SUM_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				total_q     <= chr.last ? '0 : sat;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q     <= chr.cp;
			nbytes_q <= chr.nbytes;
			cols_q   <= cols;
			pix_q    <= PIX_W'(sat);
			last_q   <= chr.last;
		end
	end

	assign chars.valid        = out_valid_q;
	assign chars.code_point   = cp_q;
	assign chars.byte_count   = nbytes_q;
	assign chars.columns      = cols_q;
	assign chars.width_pixels = pix_q;
	assign chars.run_last     = last_q;

endmodule

@@ rtl/core/utf8_decode_column_width.sv @@
// a byte completing a character reaches chars via the queue, decode stage and output registers
// throughput: one byte per cycle if chars is ready; bytes after a bad lead are decoded again
// the decode window sets the rate: one character a cycle to the width stage while that is ready
// reset: arst_n asynchronous, active low; clears queue, open sequence, pixel total and
// output valid; cell width returns to 8
// ----------------------------------------------------------------------------
// utf8_decode_column_width
// utf-8 byte stream to characters with display columns and running pixel width
// ----------------------------------------------------------------------------
module utf8_decode_column_width (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ucw_pkg::CELL_W-1:0] cfg_wr_data,
	ucw_byte_if.sink                   bytes,
	ucw_char_if.source                 chars
);
	import ucw_pkg::*;

	// pixels per display column
	logic [CELL_W-1:0] cell_width_q;

	// front to back: head of the classified byte queue
	byte_ent_t q_head;
	logic      q_valid;
	logic      q_pop;

	// decode to width stage
	char_t     chr;
	logic      chr_valid;
	logic      chr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q <= CELL_RESET;
		end else if (cfg_wr_en) begin
			cell_width_q <= cfg_wr_data;
		end
	end

	// front: take bytes, tag lead length and continuation, queue them
	ucw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.head       (q_head),
		.head_valid (q_valid),
		.head_pop   (q_pop)
	);

	// back: open sequence window, one character item per cycle while the width stage takes them
	ucw_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_valid),
		.head_pop   (q_pop),
		.chr        (chr),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready)
	);

	// width lookup and running pixel sum, registered output
	ucw_width u_width (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_width (cell_width_q),
		.chr        (chr),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.chars      (chars)
	);

`ifndef NO_ASSERTIONS
	// a one-byte item carries at most a byte value
	a_single_raw: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.byte_count == 3'd1 |-> chars.code_point[CP_W-1:BYTE_W] == '0)
		else $error("one-byte item with wide code point");

	// byte count is always one to four
	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid |-> chars.byte_count != 3'd0 && chars.byte_count <= 3'd4)
		else $error("illegal byte count");

	// queue refuses bytes only while it holds some
	a_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> q_valid)
		else $error("queue stalls while empty");

	// two-byte items fit in eleven bits
	a_two_byte: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.byte_count == 3'd2 |-> chars.code_point[CP_W-1:11] == '0)
		else $error("two-byte item out of range");
`endif

endmodule
